@@ rtl/tmp_pkg.sv @@
// Shared types and constants for the trapezoid motion profile core.
// No dependencies; imported by the top level.
package tmp_pkg;

  localparam int VALUE_WIDTH = 32;           // width of distance and time operands and results
  localparam int FIELD_W    = VALUE_WIDTH;  // width of value fields on the item ports
  localparam int SPEED_W    = 23;
  localparam int ACCEL_W    = 21;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 2;
  localparam int CAP_W      = 63;  // internal times clamp at 2^62

  localparam logic [CAP_W-1:0] WIDE_CAP = {1'b1, {(CAP_W-1){1'b0}}};

  localparam logic [CFG_IDX_W-1:0] REG_LEG   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPEED = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL = 2'd2;

  typedef enum logic [1:0] {
    PH_ACCEL  = 2'd0,
    PH_CRUISE = 2'd1,
    PH_BRAKE  = 2'd2
  } phase_t;

  typedef struct packed {
    logic               cmd;
    logic [FIELD_W-1:0] operand_value;
  } in_item_t;

  typedef struct packed {
    logic [FIELD_W-1:0] result_value;
    phase_t             profile_phase;
    logic               saturated;
  } out_item_t;

endpackage

@@ rtl/tmp_div_pipe.sv @@
// Pipelined restoring divider, one quotient bit per stage, tag carried alongside.
// Standalone; used by the trapezoid motion profile core.
module tmp_div_pipe #(
  parameter int NUM_W = 64,
  parameter int DEN_W = 23,
  parameter int TAG_W = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             en,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] num,
  input  logic [DEN_W-1:0] den,
  input  logic [TAG_W-1:0] tag,
  output logic             out_valid,
  output logic [NUM_W-1:0] quo,
  output logic [TAG_W-1:0] out_tag
);

  logic [NUM_W-1:0] s_valid;
  logic [NUM_W-1:0] s_num [NUM_W];
  logic [NUM_W-1:0] s_quo [NUM_W];
  logic [DEN_W-1:0] s_rem [NUM_W];
  logic [DEN_W-1:0] s_den [NUM_W];
  logic [TAG_W-1:0] s_tag [NUM_W];

  logic             p_valid [NUM_W];
  logic [NUM_W-1:0] p_num   [NUM_W];
  logic [NUM_W-1:0] p_quo   [NUM_W];
  logic [DEN_W-1:0] p_rem   [NUM_W];
  logic [DEN_W-1:0] p_den   [NUM_W];
  logic [TAG_W-1:0] p_tag   [NUM_W];
  logic [DEN_W:0]   trial   [NUM_W];
  logic             take    [NUM_W];

  always_comb begin
    p_valid[0] = in_valid;
    p_num[0]   = num;
    p_quo[0]   = '0;
    p_rem[0]   = '0;
    p_den[0]   = den;
    p_tag[0]   = tag;
    for (int i = 1; i < NUM_W; i++) begin
      p_valid[i] = s_valid[i-1];
      p_num[i]   = s_num[i-1];
      p_quo[i]   = s_quo[i-1];
      p_rem[i]   = s_rem[i-1];
      p_den[i]   = s_den[i-1];
      p_tag[i]   = s_tag[i-1];
    end
    for (int i = 0; i < NUM_W; i++) begin
      trial[i] = {p_rem[i], p_num[i][NUM_W-1-i]};
      take[i]  = trial[i] >= {1'b0, p_den[i]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= '0;
    end else if (en) begin
      for (int i = 0; i < NUM_W; i++) s_valid[i] <= p_valid[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NUM_W; i++) begin
        s_num[i] <= p_num[i];
        s_den[i] <= p_den[i];
        s_tag[i] <= p_tag[i];
        s_quo[i] <= p_quo[i] | (take[i] ? (NUM_W'(1) << (NUM_W-1-i)) : '0);
        // remainder stays below the divisor, so it fits DEN_W bits
        s_rem[i] <= take[i] ? DEN_W'(trial[i] - {1'b0, p_den[i]})
                            : trial[i][DEN_W-1:0];
      end
    end
  end

  assign out_valid = s_valid[NUM_W-1];
  assign quo       = s_quo[NUM_W-1];
  assign out_tag   = s_tag[NUM_W-1];

endmodule

@@ rtl/tmp_sqrt_pipe.sv @@
// Pipelined integer square root, one root bit per stage, operand passed through.
// Standalone; used by the trapezoid motion profile core.
module tmp_sqrt_pipe #(
  parameter int X_W   = 64,
  parameter int TAG_W = 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic                   in_valid,
  input  logic [X_W-1:0]         x,
  input  logic [TAG_W-1:0]       tag,
  output logic                   out_valid,
  output logic [(X_W+1)/2-1:0]   root,
  output logic [X_W-1:0]         x_out,
  output logic [TAG_W-1:0]       out_tag
);

  localparam int ROOT_W = (X_W + 1) / 2;

  logic [ROOT_W-1:0] s_valid;
  logic [X_W-1:0]    s_x    [ROOT_W];
  logic [ROOT_W-1:0] s_root [ROOT_W];
  logic [X_W-1:0]    s_sq   [ROOT_W];   // square of the partial root
  logic [TAG_W-1:0]  s_tag  [ROOT_W];

  logic              p_valid [ROOT_W];
  logic [X_W-1:0]    p_x     [ROOT_W];
  logic [ROOT_W-1:0] p_root  [ROOT_W];
  logic [X_W-1:0]    p_sq    [ROOT_W];
  logic [TAG_W-1:0]  p_tag   [ROOT_W];
  logic [X_W+1:0]    cand    [ROOT_W];
  logic              take    [ROOT_W];

  always_comb begin
    p_valid[0] = in_valid;
    p_x[0]     = x;
    p_root[0]  = '0;
    p_sq[0]    = '0;
    p_tag[0]   = tag;
    for (int j = 1; j < ROOT_W; j++) begin
      p_valid[j] = s_valid[j-1];
      p_x[j]     = s_x[j-1];
      p_root[j]  = s_root[j-1];
      p_sq[j]    = s_sq[j-1];
      p_tag[j]   = s_tag[j-1];
    end
    // (r + 2^b)^2 = r^2 + r*2^(b+1) + 2^(2b)
    for (int j = 0; j < ROOT_W; j++) begin
      cand[j] = {2'b00, p_sq[j]}
              + ((X_W+2)'(p_root[j]) << (ROOT_W - j))
              + ((X_W+2)'(1) << (2 * (ROOT_W - 1 - j)));
      take[j] = cand[j] <= {2'b00, p_x[j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= '0;
    end else if (en) begin
      for (int j = 0; j < ROOT_W; j++) s_valid[j] <= p_valid[j];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int j = 0; j < ROOT_W; j++) begin
        s_x[j]   <= p_x[j];
        s_tag[j] <= p_tag[j];
        s_root[j] <= p_root[j] | (take[j] ? (ROOT_W'(1) << (ROOT_W-1-j)) : '0);
        s_sq[j]   <= take[j] ? cand[j][X_W-1:0] : p_sq[j];
      end
    end
  end

  assign out_valid = s_valid[ROOT_W-1];
  assign root      = s_root[ROOT_W-1];
  assign x_out     = s_x[ROOT_W-1];
  assign out_tag   = s_tag[ROOT_W-1];

endmodule

@@ rtl/trapezoid_motion_profile_core.sv @@
// Trapezoid motion profile core: top level with config, setup sequencer and item pipeline.
// Depends on tmp_pkg, tmp_div_pipe and tmp_sqrt_pipe.
//
// Converts a distance along one stop-to-stop leg into elapsed time (cmd 0) or a time
// into travelled distance (cmd 1) for a symmetric accelerate/cruise/brake profile,
// all in unsigned fixed point (Q16.16 at the default FRAC_BITS). One item is taken per
// clock while setup is done and the output is not stalled; every item passes through the
// bit-per-stage divider and square-root pipelines. After reset and after every register
// write the block derives ramp distance, peak speed, ramp time and leg duration by
// sending four operations through the same pipelines; in_ready stays low until the
// fourth has finished, and after a write the pipelines are drained first.
// Write registers only when no item is outstanding.
module trapezoid_motion_profile_core #(
  parameter int FRAC_BITS   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  tmp_pkg::in_item_t              in_item,
  output logic                           out_valid,
  input  logic                           out_ready,
  output tmp_pkg::out_item_t             out_item,
  input  logic                           cfg_we,
  input  logic [tmp_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tmp_pkg::CFG_DATA_W-1:0] cfg_data
);

  import tmp_pkg::*;

  localparam int W      = VALUE_WIDTH;
  localparam int F      = FRAC_BITS;
  // time from rest needs 2*d shifted by 2F, one bit above W + 2F
  localparam int NUM_W  = (W + 2*F + 1 > 2*SPEED_W) ? W + 2*F + 1 : 2*SPEED_W;
  localparam int ROOT_W = (NUM_W + 1) / 2;
  localparam int X_W    = (W > ROOT_W) ? W : ROOT_W;
  localparam int TW     = CAP_W;
  localparam int CW     = ((NUM_W > TW) ? NUM_W : TW) + 2;
  localparam int H      = (ROOT_W + 1) / 2;
  localparam int SQ_W   = 2 * ROOT_W;
  localparam int PROD_W = SQ_W + ACCEL_W;
  localparam int PK_W   = SPEED_W + W;
  localparam int LAT    = NUM_W + ROOT_W;
  localparam int CNT_W  = $clog2(LAT + 1);
  localparam int EPS_I  = ((1 << F) + 500) / 1000;
  localparam logic [SPEED_W-1:0] EPS = (EPS_I > 0) ? SPEED_W'(EPS_I) : SPEED_W'(1);
  localparam logic [63:0]  ONE_Q = 64'(1) << F;
  localparam logic [TW:0]  MAXV  = (TW+1)'((65'(1) << W) - 65'(1));

  typedef struct packed {
    logic           prep;
    logic           cmd;
    phase_t         phase;
    logic [X_W-1:0] x;
  } tag_t;
  localparam int TAG_W = $bits(tag_t);

  typedef enum logic [2:0] {
    P_FLUSH, P_RAMP, P_PEAK, P_RT, P_CRUISE, P_DONE
  } pstate_t;

  // configuration
  logic [W-1:0]       leg;
  logic [SPEED_W-1:0] speed;
  logic [ACCEL_W-1:0] accel;
  logic [SPEED_W-1:0] v_e;
  logic [ACCEL_W-1:0] a_e;

  // derived profile
  logic [W-1:0]       ramp;
  logic [SPEED_W-1:0] peak;
  logic [SPEED_W-1:0] divr;
  logic [ROOT_W-1:0]  rt;
  logic [TW-1:0]      dur;

  pstate_t            pstate;
  logic               issued;
  logic [CNT_W-1:0]   flush_cnt;

  logic adv;
  logic acc;

  assign v_e = (speed == '0) ? SPEED_W'(1) : speed;
  assign a_e = (accel == '0) ? ACCEL_W'(1) : accel;

  always_ff @(posedge clk) begin
    if (rst) begin
      leg   <= '0;
      speed <= ONE_Q[SPEED_W-1:0];
      accel <= ONE_Q[ACCEL_W-1:0];
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEG:   leg   <= W'(cfg_data);
        REG_SPEED: speed <= cfg_data[SPEED_W-1:0];
        REG_ACCEL: accel <= cfg_data[ACCEL_W-1:0];
        default: ;
      endcase
    end
  end

  // setup operations driven into the shared pipelines
  logic [2*SPEED_W-1:0]   v_sq;
  logic [ACCEL_W+W:0]     a2_ramp;
  logic                   prep_go;
  logic [NUM_W-1:0]       prep_num;
  logic [SPEED_W-1:0]     prep_den;

  assign v_sq    = v_e * v_e;
  assign a2_ramp = {a_e, 1'b0} * ramp;
  assign prep_go = (pstate != P_DONE) && (pstate != P_FLUSH) && !issued;

  always_comb begin
    prep_num = '0;
    prep_den = SPEED_W'(1);
    unique case (pstate)
      P_RAMP: begin
        prep_num = NUM_W'(v_sq);
        prep_den = SPEED_W'({a_e, 1'b0});
      end
      P_PEAK: prep_num = NUM_W'(a2_ramp);
      P_RT: begin
        prep_num = NUM_W'({ramp, 1'b0}) << (2*F);
        prep_den = SPEED_W'(a_e);
      end
      P_CRUISE: begin
        prep_num = NUM_W'(leg - {ramp[W-2:0], 1'b0}) << F;
        prep_den = divr;
      end
      P_FLUSH, P_DONE: ;
      default: ;
    endcase
  end

  // item pipeline front: accept, clamp, phase select
  logic               a_valid, b_valid, c_valid;
  logic               a_cmd, b_cmd;
  logic [W-1:0]       a_op, b_c;
  tag_t               c_tag;
  tag_t               c_next;

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv && (pstate == P_DONE);
  assign acc      = in_valid && in_ready;

  always_comb begin
    c_next      = '0;
    c_next.cmd  = b_cmd;
    if (!b_cmd) begin
      if (b_c < ramp) begin
        c_next.phase = PH_ACCEL;
        c_next.x     = X_W'(b_c);
      end else if (b_c > leg - ramp) begin
        c_next.phase = PH_BRAKE;
        c_next.x     = X_W'(leg - b_c);
      end else begin
        c_next.phase = PH_CRUISE;
        c_next.x     = X_W'(b_c - ramp);
      end
    end else begin
      if (TW'(b_c) < TW'(rt)) begin
        c_next.phase = PH_ACCEL;
        c_next.x     = X_W'(b_c);
      end else if (TW'(b_c) > dur - TW'(rt)) begin
        c_next.phase = PH_BRAKE;
        c_next.x     = X_W'(dur - TW'(b_c));
      end else begin
        c_next.phase = PH_CRUISE;
        c_next.x     = X_W'(TW'(b_c) - TW'(rt));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
      c_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= acc;
      b_valid <= a_valid;
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_cmd <= in_item.cmd;
      a_op  <= W'(in_item.operand_value);
      b_cmd <= a_cmd;
      if (!a_cmd) b_c <= (a_op < leg) ? a_op : leg;
      else        b_c <= (TW'(a_op) < dur) ? a_op : W'(dur);
      c_tag <= c_next;
    end
  end

  // shared divider and square root
  logic             div_in_valid;
  logic [NUM_W-1:0] div_num;
  logic [SPEED_W-1:0] div_den;
  tag_t             div_tag;
  logic             div_out_valid;
  logic [NUM_W-1:0] div_quo;
  logic [TAG_W-1:0] div_out_tag;
  logic             sq_valid;
  logic [ROOT_W-1:0] sq_root;
  logic [NUM_W-1:0] sq_quo;
  logic [TAG_W-1:0] sq_tag_bits;
  tag_t             sq_tag;
  logic             prep_done;

  always_comb begin
    div_tag = '0;
    if (pstate != P_DONE) begin
      div_in_valid = prep_go;
      div_num      = prep_num;
      div_den      = prep_den;
      div_tag.prep = 1'b1;
    end else begin
      div_in_valid = c_valid;
      div_tag      = c_tag;
      if (c_tag.phase == PH_CRUISE) begin
        div_num = NUM_W'(c_tag.x) << F;
        div_den = divr;
      end else begin
        div_num = NUM_W'(c_tag.x) << (2*F + 1);
        div_den = SPEED_W'(a_e);
      end
    end
  end

  tmp_div_pipe #(
    .NUM_W(NUM_W), .DEN_W(SPEED_W), .TAG_W(TAG_W)
  ) u_div (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(div_in_valid), .num(div_num), .den(div_den), .tag(div_tag),
    .out_valid(div_out_valid), .quo(div_quo), .out_tag(div_out_tag)
  );

  tmp_sqrt_pipe #(
    .X_W(NUM_W), .TAG_W(TAG_W)
  ) u_sqrt (
    .clk(clk), .rst(rst), .en(adv),
    .in_valid(div_out_valid), .x(div_quo), .tag(div_out_tag),
    .out_valid(sq_valid), .root(sq_root), .x_out(sq_quo), .out_tag(sq_tag_bits)
  );

  assign sq_tag    = tag_t'(sq_tag_bits);
  assign prep_done = sq_valid && sq_tag.prep && adv;

  // setup sequencer
  logic [CW-1:0] cru_w;
  logic [CW-1:0] dur_w;

  always_comb begin
    cru_w = (CW'(sq_quo) > CW'(WIDE_CAP)) ? CW'(WIDE_CAP) : CW'(sq_quo);
    dur_w = (CW'(rt) << 1) + cru_w;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pstate    <= P_RAMP;
      issued    <= 1'b0;
      flush_cnt <= '0;
    end else if (cfg_we) begin
      // drain any setup operation still in flight before starting over
      pstate    <= P_FLUSH;
      issued    <= 1'b0;
      flush_cnt <= CNT_W'(LAT);
    end else begin
      if (prep_go && adv) issued <= 1'b1;
      unique case (pstate)
        P_FLUSH: begin
          if (adv) begin
            if (flush_cnt == '0) pstate <= P_RAMP;
            else                 flush_cnt <= flush_cnt - CNT_W'(1);
          end
        end
        P_RAMP: begin
          if (prep_done) begin
            issued <= 1'b0;
            pstate <= P_PEAK;
            ramp   <= (sq_quo > NUM_W'(leg >> 1)) ? (leg >> 1) : W'(sq_quo);
          end
        end
        P_PEAK: begin
          if (prep_done) begin
            issued <= 1'b0;
            pstate <= P_RT;
            peak   <= SPEED_W'(sq_root);
            divr   <= (SPEED_W'(sq_root) > EPS) ? SPEED_W'(sq_root) : EPS;
          end
        end
        P_RT: begin
          if (prep_done) begin
            issued <= 1'b0;
            pstate <= P_CRUISE;
            rt     <= sq_root;
          end
        end
        P_CRUISE: begin
          if (prep_done) begin
            issued <= 1'b0;
            pstate <= P_DONE;
            dur    <= (dur_w > CW'(WIDE_CAP)) ? WIDE_CAP : TW'(dur_w);
          end
        end
        P_DONE: ;
        default: pstate <= P_RAMP;
      endcase
    end
  end

  // item pipeline back: multiplies and result assembly
  logic                  d_valid, e_valid, f_valid, g_valid;
  logic                  d_cmd, e_cmd, f_cmd, g_cmd;
  phase_t                d_phase, e_phase, f_phase, g_phase;
  logic [ROOT_W-1:0]     d_root, e_root, f_root;
  logic [TW-1:0]         d_q, e_q, f_q;
  logic [PK_W-1:0]       d_pk, e_pk, f_pk;
  logic [2*(ROOT_W-H)-1:0] d_hh;
  logic [ROOT_W-1:0]     d_hl;
  logic [2*H-1:0]        d_ll;
  logic [SQ_W-1:0]       e_sq;
  logic [ROOT_W+ACCEL_W-1:0] f_mh, f_ml;
  logic [TW:0]           g_val;

  logic [ROOT_W-1:0]     y;
  logic [PROD_W-1:0]     prod;
  logic [PROD_W-1:0]     prod_sh;
  logic [TW-1:0]         dfr;
  logic [TW:0]           g_next;

  assign y = ROOT_W'(sq_tag.x);

  always_comb begin
    prod    = (PROD_W'(f_mh) << ROOT_W) + PROD_W'(f_ml);
    prod_sh = prod >> (2*F + 1);
    dfr     = ((PROD_W + 1)'(prod_sh) > (PROD_W + 1)'(WIDE_CAP)) ? WIDE_CAP
                                                                 : TW'(prod_sh);
    g_next  = '0;
    if (!f_cmd) begin
      unique case (f_phase)
        PH_ACCEL:  g_next = (TW+1)'(f_root);
        PH_BRAKE:  g_next = (dur >= TW'(f_root)) ? (TW+1)'(dur - TW'(f_root)) : '0;
        PH_CRUISE: g_next = (TW+1)'(rt) + (TW+1)'(f_q);
        default:   g_next = '0;
      endcase
    end else begin
      if (f_phase == PH_CRUISE) g_next = (TW+1)'(ramp) + (TW+1)'(f_pk >> F);
      else                      g_next = (TW+1)'(dfr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
      e_valid <= 1'b0;
      f_valid <= 1'b0;
      g_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= sq_valid && !sq_tag.prep;
      e_valid <= d_valid;
      f_valid <= e_valid;
      g_valid <= f_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_cmd   <= sq_tag.cmd;
      d_phase <= sq_tag.phase;
      d_root  <= sq_root;
      d_q     <= (CW'(sq_quo) > CW'(WIDE_CAP)) ? WIDE_CAP : TW'(sq_quo);
      d_hh    <= y[ROOT_W-1:H] * y[ROOT_W-1:H];
      d_hl    <= ROOT_W'(y[ROOT_W-1:H] * y[H-1:0]);
      d_ll    <= y[H-1:0] * y[H-1:0];
      d_pk    <= peak * W'(sq_tag.x);

      e_cmd   <= d_cmd;
      e_phase <= d_phase;
      e_root  <= d_root;
      e_q     <= d_q;
      e_pk    <= d_pk;
      e_sq    <= (SQ_W'(d_hh) << (2*H)) + (SQ_W'(d_hl) << (H + 1)) + SQ_W'(d_ll);

      f_cmd   <= e_cmd;
      f_phase <= e_phase;
      f_root  <= e_root;
      f_q     <= e_q;
      f_pk    <= e_pk;
      f_mh    <= e_sq[SQ_W-1:ROOT_W] * a_e;
      f_ml    <= e_sq[ROOT_W-1:0] * a_e;

      g_cmd   <= f_cmd;
      g_phase <= f_phase;
      g_val   <= g_next;
    end
  end

  // output register
  logic [TW:0]  dist_raw;
  logic [W-1:0] res_w;
  logic         sat_w;

  always_comb begin
    sat_w    = 1'b0;
    dist_raw = g_val;
    if (!g_cmd) begin
      sat_w = g_val > MAXV;
      res_w = sat_w ? MAXV[W-1:0] : g_val[W-1:0];
    end else begin
      if (g_phase == PH_BRAKE)
        dist_raw = ((TW+1)'(leg) >= g_val) ? (TW+1)'(leg) - g_val : '0;
      res_w = (dist_raw > (TW+1)'(leg)) ? leg : dist_raw[W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= g_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_item.result_value  <= FIELD_W'(res_w);
      out_item.profile_phase <= g_phase;
      out_item.saturated     <= sat_w;
    end
  end

  // checks
  a_prep_not_after_done: assert property (@(posedge clk) disable iff (rst)
    (sq_valid && sq_tag.prep) |-> (pstate != P_DONE))
    else $error("setup result seen after setup finished");

  a_cfg_blocks_items: assert property (@(posedge clk) disable iff (rst)
    cfg_we |=> !in_ready)
    else $error("items accepted straight after a register write");

  a_sat_is_max: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.saturated) |->
      (out_item.result_value == FIELD_W'(MAXV[W-1:0])))
    else $error("saturated item without full-scale value");

endmodule

@@ verif/tb_trapezoid_motion_profile_core.sv @@
`timescale 1ns / 100ps
// Testbench for trapezoid_motion_profile_core: directed and random distance/time
// conversions under several register settings, checked against an in-bench profile model.
// Depends on tmp_pkg and the core RTL.

module tb_trapezoid_motion_profile_core;
  import tmp_pkg::*;

  localparam int FB = 16;
  localparam longint unsigned MAXV = 64'hFFFF_FFFF;
  localparam longint unsigned TCAP = 64'd1 << 62;
  localparam longint unsigned EPS = (64'd65536 + 64'd500) / 64'd1000;
  localparam int LIMIT = 3000000;

  // 128-bit helpers: exact wide arithmetic for the profile maths
  function automatic logic [127:0] isqrt128(logic [127:0] x);
    logic [63:0] r;
    logic [63:0] c;
    r = 0;
    for (int b = 63; b >= 0; b--) begin
      c = r | (64'd1 << b);
      if (128'(c) * 128'(c) <= x) r = c;
    end
    return 128'(r);
  endfunction

  function automatic longint unsigned cap62(logic [127:0] x);
    if (x > 128'(TCAP)) return TCAP;
    return x[63:0];
  endfunction

  function automatic longint unsigned rest_time(longint unsigned d, longint unsigned a);
    logic [127:0] n;
    n = (128'(d) * 2) << (2 * FB);
    return isqrt128(n / 128'(a));
  endfunction

  function automatic longint unsigned rest_dist(longint unsigned t, longint unsigned a);
    logic [191:0] p;
    p = 192'(t) * 192'(t) * 192'(a);
    p = p >> (2 * FB + 1);
    if (p > 192'(TCAP)) return TCAP;
    return p[63:0];
  endfunction

  class profile_scoreboard;
    longint unsigned leg, speed, accel;
    out_item_t pending[$];
    int mismatches, checked;

    function void reset_regs();
      leg = 0; speed = 65536; accel = 65536;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
      case (idx)
        REG_LEG:   leg = d;
        REG_SPEED: speed = d[SPEED_W-1:0];
        REG_ACCEL: accel = d[ACCEL_W-1:0];
        default: ;
      endcase
    endfunction

    function out_item_t convert(in_item_t it);
      longint unsigned a, v, ramp, peak, dv, rt, dur, res, x, s, op;
      phase_t ph;
      logic sat;
      out_item_t o;
      a = accel ? accel : 1;
      v = speed ? speed : 1;
      op = it.operand_value;
      sat = 0;
      ramp = (v * v) / (2 * a);
      if (ramp > leg / 2) ramp = leg / 2;
      peak = isqrt128(128'(2 * a * ramp));
      dv = peak > EPS ? peak : EPS;
      rt = rest_time(ramp, a);
      dur = 2 * rt + cap62((128'(leg - 2 * ramp) << FB) / 128'(dv));
      if (dur > TCAP) dur = TCAP;
      if (!it.cmd) begin
        x = op < leg ? op : leg;
        if (x < ramp) begin
          res = rest_time(x, a); ph = PH_ACCEL;
        end else if (x > leg - ramp) begin
          s = rest_time(leg - x, a);
          res = dur >= s ? dur - s : 0; ph = PH_BRAKE;
        end else begin
          res = rt + cap62((128'(x - ramp) << FB) / 128'(dv)); ph = PH_CRUISE;
        end
        if (res > MAXV) begin
          res = MAXV; sat = 1;
        end
      end else begin
        x = op < dur ? op : dur;
        if (x < rt) begin
          res = rest_dist(x, a); ph = PH_ACCEL;
        end else if (x > dur - rt) begin
          s = rest_dist(dur - x, a);
          res = leg >= s ? leg - s : 0; ph = PH_BRAKE;
        end else begin
          res = ramp + cap62((128'(peak) * 128'(x - rt)) >> FB); ph = PH_CRUISE;
        end
        if (res > leg) res = leg;
      end
      o.result_value = res[31:0];
      o.profile_phase = ph;
      o.saturated = sat;
      return o;
    endfunction

    function void note_item(in_item_t it);
      pending = {pending, convert(it)};
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      e = pending.pop_front();
      if (got.result_value !== e.result_value || got.profile_phase !== e.profile_phase
          || got.saturated !== e.saturated) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: exp val %h ph %0d sat %b, got val %h ph %0d sat %b",
                   e.result_value, e.profile_phase, e.saturated,
                   got.result_value, got.profile_phase, got.saturated);
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  in_item_t in_item = '0;
  out_item_t out_item;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_LEG;
  logic [CFG_DATA_W-1:0] cfg_data = 0;

  profile_scoreboard sb = new();
  int cycles = 0;
  int hold_off = 0;      // long receiver hold-off length, set by stimulus
  bit quiet = 0;         // no idling in the final stretch
  int sent = 0;

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  trapezoid_motion_profile_core u_dut (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, plus one long hold-off on request
  initial begin
    int n;
    forever begin
      @(posedge clk);
      if (hold_off > 0) begin
        out_ready <= 0;
        n = hold_off;
        hold_off = 0;
        repeat (n) @(posedge clk);
        out_ready <= 1;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        out_ready <= 0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
        out_ready <= 1;
      end else begin
        out_ready <= 1;
      end
    end
  end

  always @(posedge clk)
    if (!rst && out_valid && out_ready) sb.check_result(out_item);

  task automatic send_item(logic c, logic [31:0] v, bit may_idle);
    if (may_idle && !quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid <= 1;
    in_item <= '{cmd: c, operand_value: v};
    do @(posedge clk); while (!in_ready);
    sb.note_item('{cmd: c, operand_value: v});
    sent++;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
  endtask

  task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] d);
    cfg_we <= 1; cfg_index <= idx; cfg_data <= d;
    @(posedge clk);
    sb.write_reg(idx, d);
    cfg_we <= 0;
  endtask

  // operands aimed at the phase boundaries of the current setting
  function automatic logic [31:0] rand_operand(logic c);
    longint unsigned l;
    l = sb.leg;
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return l == 0 ? 0 : $urandom_range(0, l[31:0]);
      2: return l[31:0] + $urandom_range(0, 3) - 1;
      3: return $urandom_range(0, 255);
      4: return c ? $urandom_range(0, 32'h00FF_FFFF) : l[31:0] - $urandom_range(0, 65535);
      default: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
    endcase
  endfunction

  task automatic run_setting(logic [31:0] l, logic [31:0] v, logic [31:0] a, int n,
                             bit may_idle);
    logic c;
    drain();
    write_cfg(REG_LEG, l);
    write_cfg(REG_SPEED, v);
    write_cfg(REG_ACCEL, a);
    for (int i = 0; i < n; i++) begin
      c = $urandom_range(0, 1);
      send_item(c, rand_operand(c), may_idle);
    end
  endtask

  initial begin
    sb.reset_regs();
    repeat (3) @(posedge clk);
    rst <= 0;

    // directed: reset setting (zero leg), then extremes of each field
    send_item(0, 0, 0);
    send_item(1, 32'hFFFF_FFFF, 0);
    drain();
    write_cfg(REG_LEG, 32'h0064_0000);
    send_item(0, 0, 0);
    send_item(0, 32'h0001_0000, 0);
    send_item(0, 32'h0032_0000, 0);
    send_item(0, 32'h0063_8000, 0);
    send_item(0, 32'hFFFF_FFFF, 0);
    send_item(1, 0, 0);
    send_item(1, 32'h0000_8000, 0);
    send_item(1, 32'h0032_0000, 0);
    send_item(1, 32'h0065_0000, 0);
    send_item(1, 32'hFFFF_FFFF, 0);
    // zero speed and acceleration registers: taken as one LSB, long times saturate
    run_setting(32'hFFFF_FFFF, 0, 0, 6, 0);
    run_setting(32'hFFFF_FFFF, 32'h7F_FFFF, 32'h1F_FFFF, 6, 0);
    run_setting(32'h0000_0001, 6553600, 1310720, 4, 0);

    // random settings including extremes
    run_setting(32'hFFFF_FFFF, 6553600, 1310720, 150, 1);
    run_setting(32'h0010_0000, 1, 1, 150, 1);
    run_setting($urandom, $urandom_range(1, 6553600), $urandom_range(1, 1310720), 200, 1);

    // long receiver hold-off while the sender keeps offering
    hold_off = 400;
    for (int i = 0; i < 200; i++) send_item(i[0], rand_operand(i[0]), 0);
    // sender pauses until every result is back
    drain();

    run_setting(32'h00C8_0000, 32'h000A_0000, 32'h0002_0000, 250, 1);
    run_setting($urandom, $urandom_range(1, 65536), $urandom_range(1, 65536), 250, 1);
    run_setting($urandom_range(0, 32'hFFFF), $urandom, $urandom, 200, 1);
    run_setting($urandom, $urandom_range(1, 6553600), $urandom_range(1, 1310720), 250, 1);
    quiet = 1;
    run_setting($urandom, $urandom_range(1, 6553600), $urandom_range(1, 1310720), 250, 0);

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (130) @(posedge clk);
    $display("Covered %0d items over zero, minimal, maximal and random legs/speeds/rates;",
             sent);
    $display("%0d results checked, %0d mismatches.", sb.checked, sb.mismatches);
    if (sb.mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
